[sv/gtr_pkg.sv]
`default_nettype none
package gtr_pkg;

   localparam int COORD_W    = 16;
   localparam int TIME_W     = 32;
   localparam int STEP_W     = COORD_W + 1;
   localparam int POS_W      = 17;
   localparam int DUR_W      = 32;
   localparam int THR_W      = 8;
   localparam int THR_SQ_W   = 2 * THR_W;
   localparam int ORIGIN_W   = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int SQ_W       = 2 * STEP_W + 1;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [THR_W-1:0] THR_RESET = THR_W'(8);

   localparam logic [CSR_IDX_W-1:0] CSR_SWIPE_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y        = 2'd2;

   typedef enum logic [1:0] {
      EV_PRESSED  = 2'd0,
      EV_RELEASED = 2'd1,
      EV_DRAGGED  = 2'd2,
      EV_SWIPED   = 2'd3
   } event_kind_type;

   typedef logic signed [COORD_W-1:0]  coord_type;
   typedef logic signed [STEP_W-1:0]   step_type;
   typedef logic signed [POS_W-1:0]    pos_type;
   typedef logic signed [ORIGIN_W-1:0] origin_type;
   typedef logic [TIME_W-1:0]          time_type;

   typedef struct packed {
      event_kind_type    kind;
      logic [DUR_W-1:0]  duration;
      pos_type           from_x;
      pos_type           from_y;
      pos_type           to_x;
      pos_type           to_y;
      logic              last;
   } rec_type;

   typedef struct packed {
      logic    first;
      logic    second;
      rec_type rec0;
      rec_type rec1;
   } push_type;

   typedef struct packed {
      logic [THR_SQ_W-1:0] thr_sq;
      origin_type          origin_x;
      origin_type          origin_y;
   } cfg_type;

endpackage
`default_nettype wire

[sv/gtr_rsp_fifo.sv]
`default_nettype none
module gtr_rsp_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire gtr_pkg::push_type push,
   output logic                   room,
   output logic                   head_valid,
   output gtr_pkg::rec_type       head,
   input  wire logic              pop_ready
);

   gtr_pkg::rec_type                   mem_ff [gtr_pkg::FIFO_DEPTH];
   logic [gtr_pkg::FIFO_PTR_W-1:0]     wr_ff, wr_in;
   logic [gtr_pkg::FIFO_PTR_W-1:0]     rd_ff, rd_in;
   logic [gtr_pkg::FIFO_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [gtr_pkg::FIFO_PTR_W-1:0]     wr_next;
   logic                               pop;

   // room for a full pair of results, whatever is popped this cycle
   assign room       = cnt_ff <= gtr_pkg::FIFO_CNT_W'(gtr_pkg::FIFO_DEPTH - 2);
   assign head_valid = cnt_ff != '0;
   assign head       = mem_ff[rd_ff];
   assign pop        = head_valid && pop_ready;
   assign wr_next    = wr_ff + gtr_pkg::FIFO_PTR_W'(1);

   always_comb begin
      wr_in  = wr_ff + gtr_pkg::FIFO_PTR_W'(push.first) + gtr_pkg::FIFO_PTR_W'(push.second);
      rd_in  = rd_ff + gtr_pkg::FIFO_PTR_W'(pop);
      cnt_in = cnt_ff + gtr_pkg::FIFO_CNT_W'(push.first) + gtr_pkg::FIFO_CNT_W'(push.second)
               - gtr_pkg::FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.first) begin
         mem_ff[wr_ff] <= push.rec0;
      end
      if (push.second) begin
         mem_ff[wr_next] <= push.rec1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

[sv/gtr_engine.sv]
`default_nettype none
module gtr_engine (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire gtr_pkg::cfg_type      cfg,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_pen_down,
   input  wire logic [15:0]           req_pos_x,
   input  wire logic [15:0]           req_pos_y,
   input  wire logic [31:0]           req_now_ms,
   input  wire logic                  room,
   output gtr_pkg::push_type          push
);

   logic                    in_valid_ff, in_valid_in;
   logic                    in_down_ff;
   gtr_pkg::coord_type      in_x_ff, in_y_ff;
   gtr_pkg::time_type       in_now_ff;

   logic                    pressed_ff, pressed_in;
   gtr_pkg::coord_type      press_x_ff, press_y_ff;
   gtr_pkg::coord_type      recent_x_ff, recent_y_ff;
   gtr_pkg::step_type       step_dx_ff, step_dy_ff;
   gtr_pkg::time_type       press_time_ff, recent_time_ff;

   logic                    adv, load;
   logic                    is_press, is_release, is_drag, swipe;
   logic signed [2*gtr_pkg::STEP_W-1:0] sq_x, sq_y;
   logic [gtr_pkg::SQ_W-1:0]            sq_sum;
   gtr_pkg::step_type       step_dx_new, step_dy_new;

   assign adv       = in_valid_ff && room;
   assign req_ready = !in_valid_ff || adv;
   assign load      = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (load) begin
         in_valid_in = 1'b1;
      end else if (adv) begin
         in_valid_in = 1'b0;
      end
   end

   assign is_press   = !pressed_ff && in_down_ff;
   assign is_release = pressed_ff && !in_down_ff;
   assign is_drag    = pressed_ff && in_down_ff;

   // squared length of the last step against the squared threshold
   assign sq_x   = step_dx_ff * step_dx_ff;
   assign sq_y   = step_dy_ff * step_dy_ff;
   assign sq_sum = gtr_pkg::SQ_W'(unsigned'(sq_x)) + gtr_pkg::SQ_W'(unsigned'(sq_y));
   assign swipe  = sq_sum > gtr_pkg::SQ_W'(cfg.thr_sq);

   assign step_dx_new = gtr_pkg::STEP_W'(in_x_ff) - gtr_pkg::STEP_W'(recent_x_ff);
   assign step_dy_new = gtr_pkg::STEP_W'(in_y_ff) - gtr_pkg::STEP_W'(recent_y_ff);

   always_comb begin
      push.first  = adv && (is_press || is_release || is_drag);
      push.second = adv && is_release && swipe;

      push.rec0.kind     = gtr_pkg::EV_PRESSED;
      push.rec0.duration = '0;
      push.rec0.from_x   = gtr_pkg::POS_W'(in_x_ff) - gtr_pkg::POS_W'(cfg.origin_x);
      push.rec0.from_y   = gtr_pkg::POS_W'(in_y_ff) - gtr_pkg::POS_W'(cfg.origin_y);
      push.rec0.to_x     = gtr_pkg::POS_W'(in_x_ff) - gtr_pkg::POS_W'(cfg.origin_x);
      push.rec0.to_y     = gtr_pkg::POS_W'(in_y_ff) - gtr_pkg::POS_W'(cfg.origin_y);
      push.rec0.last     = 1'b1;
      if (is_release) begin
         push.rec0.kind     = gtr_pkg::EV_RELEASED;
         push.rec0.duration = gtr_pkg::DUR_W'(in_now_ff - press_time_ff);
         push.rec0.from_x   = gtr_pkg::POS_W'(press_x_ff) - gtr_pkg::POS_W'(cfg.origin_x);
         push.rec0.from_y   = gtr_pkg::POS_W'(press_y_ff) - gtr_pkg::POS_W'(cfg.origin_y);
         push.rec0.to_x     = gtr_pkg::POS_W'(recent_x_ff) - gtr_pkg::POS_W'(cfg.origin_x);
         push.rec0.to_y     = gtr_pkg::POS_W'(recent_y_ff) - gtr_pkg::POS_W'(cfg.origin_y);
         push.rec0.last     = !swipe;
      end else if (is_drag) begin
         push.rec0.kind     = gtr_pkg::EV_DRAGGED;
         push.rec0.duration = gtr_pkg::DUR_W'(in_now_ff - press_time_ff);
         push.rec0.from_x   = gtr_pkg::POS_W'(press_x_ff) - gtr_pkg::POS_W'(cfg.origin_x);
         push.rec0.from_y   = gtr_pkg::POS_W'(press_y_ff) - gtr_pkg::POS_W'(cfg.origin_y);
      end

      // swipe starts at the point before the last step
      push.rec1.kind     = gtr_pkg::EV_SWIPED;
      push.rec1.duration = gtr_pkg::DUR_W'(in_now_ff - recent_time_ff);
      push.rec1.from_x   = gtr_pkg::POS_W'(recent_x_ff) - gtr_pkg::POS_W'(step_dx_ff)
                           - gtr_pkg::POS_W'(cfg.origin_x);
      push.rec1.from_y   = gtr_pkg::POS_W'(recent_y_ff) - gtr_pkg::POS_W'(step_dy_ff)
                           - gtr_pkg::POS_W'(cfg.origin_y);
      push.rec1.to_x     = gtr_pkg::POS_W'(recent_x_ff) - gtr_pkg::POS_W'(cfg.origin_x);
      push.rec1.to_y     = gtr_pkg::POS_W'(recent_y_ff) - gtr_pkg::POS_W'(cfg.origin_y);
      push.rec1.last     = 1'b1;
   end

   always_comb begin
      pressed_in = pressed_ff;
      if (adv) begin
         pressed_in = in_down_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         pressed_ff  <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         pressed_ff  <= pressed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         in_down_ff <= req_pen_down;
         in_x_ff    <= req_pos_x[gtr_pkg::COORD_W-1:0];
         in_y_ff    <= req_pos_y[gtr_pkg::COORD_W-1:0];
         in_now_ff  <= req_now_ms[gtr_pkg::TIME_W-1:0];
      end
      if (adv && is_press) begin
         press_x_ff     <= in_x_ff;
         press_y_ff     <= in_y_ff;
         recent_x_ff    <= in_x_ff;
         recent_y_ff    <= in_y_ff;
         step_dx_ff     <= '0;
         step_dy_ff     <= '0;
         press_time_ff  <= in_now_ff;
         recent_time_ff <= in_now_ff;
      end else if (adv && is_drag) begin
         step_dx_ff     <= step_dx_new;
         step_dy_ff     <= step_dy_new;
         recent_x_ff    <= in_x_ff;
         recent_y_ff    <= in_y_ff;
         recent_time_ff <= in_now_ff;
      end
   end

endmodule
`default_nettype wire

[sv/touch_gesture_tracker_top.sv]
// samples are registered at the engine input, then their results are written into the queue
// one sample per cycle while the queue has room; a release with swipe yields two results
// the 4-entry result queue stalls intake once fewer than 2 slots are free
// reset (synchronous, active high) clears the pen state and queue, threshold 8, origin 0
`default_nettype none
module touch_gesture_tracker_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_pen_down,
   input  wire logic [15:0] req_pos_x,
   input  wire logic [15:0] req_pos_y,
   input  wire logic [31:0] req_now_ms,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_event_kind,
   output logic [31:0]      rsp_duration_ms,
   output logic [16:0]      rsp_from_x,
   output logic [16:0]      rsp_from_y,
   output logic [16:0]      rsp_to_x,
   output logic [16:0]      rsp_to_y,
   output logic             rsp_final_of_run
);

   gtr_pkg::cfg_type   cfg_ff, cfg_in;
   gtr_pkg::push_type  push;
   gtr_pkg::rec_type   head;
   logic               room;
   logic [gtr_pkg::THR_W-1:0] thr_wr;

   assign thr_wr = csr_wdata[gtr_pkg::THR_W-1:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            gtr_pkg::CSR_SWIPE_THRESHOLD: begin
               cfg_in.thr_sq = gtr_pkg::THR_SQ_W'(thr_wr) * gtr_pkg::THR_SQ_W'(thr_wr);
            end
            gtr_pkg::CSR_ORIGIN_X: cfg_in.origin_x = csr_wdata[gtr_pkg::ORIGIN_W-1:0];
            gtr_pkg::CSR_ORIGIN_Y: cfg_in.origin_y = csr_wdata[gtr_pkg::ORIGIN_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.thr_sq   <= gtr_pkg::THR_SQ_W'(gtr_pkg::THR_RESET)
                            * gtr_pkg::THR_SQ_W'(gtr_pkg::THR_RESET);
         cfg_ff.origin_x <= '0;
         cfg_ff.origin_y <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gtr_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_pen_down (req_pen_down),
      .req_pos_x    (req_pos_x),
      .req_pos_y    (req_pos_y),
      .req_now_ms   (req_now_ms),
      .room         (room),
      .push         (push)
   );

   gtr_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (room),
      .head_valid (rsp_valid),
      .head       (head),
      .pop_ready  (rsp_ready)
   );

   assign rsp_event_kind   = head.kind;
   assign rsp_duration_ms  = head.duration;
   assign rsp_from_x       = head.from_x;
   assign rsp_from_y       = head.from_y;
   assign rsp_to_x         = head.to_x;
   assign rsp_to_y         = head.to_y;
   assign rsp_final_of_run = head.last;

endmodule
`default_nettype wire
